/* design/ezr_pkg.sv */
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared constants, types and helper functions for the ZYZ rotation matrix.
// ----------------------------------------------------------------------------
package ezr_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int FRACTION_BITS = 15;
	localparam int STEPS         = 30;
	localparam int CW            = 33;
	localparam logic signed [CW-1:0] X0 = 33'sd652032874;
	localparam int FW            = FRACTION_BITS + 2;

	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [FW-1:0] fx_t;

	function automatic cw_t atan_of(input int i);
		cw_t r;
		case (i)
			0:  r = 33'sh20000000;
			1:  r = 33'sh12E4051D;
			2:  r = 33'sh09FB385B;
			3:  r = 33'sh051111D4;
			4:  r = 33'sh028B0D43;
			5:  r = 33'sh0145D7E1;
			6:  r = 33'sh00A2F61E;
			7:  r = 33'sh00517C55;
			8:  r = 33'sh0028BE53;
			9:  r = 33'sh00145F2E;
			10: r = 33'sh000A2F98;
			11: r = 33'sh000517CC;
			12: r = 33'sh00028BE6;
			13: r = 33'sh000145F3;
			14: r = 33'sh0000A2F9;
			15: r = 33'sh0000517C;
			16: r = 33'sh000028BE;
			17: r = 33'sh0000145F;
			18: r = 33'sh00000A2F;
			19: r = 33'sh00000517;
			20: r = 33'sh0000028B;
			21: r = 33'sh00000145;
			22: r = 33'sh000000A2;
			23: r = 33'sh00000051;
			24: r = 33'sh00000028;
			25: r = 33'sh00000014;
			26: r = 33'sh0000000A;
			27: r = 33'sh00000005;
			28: r = 33'sh00000002;
			29: r = 33'sh00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round half-up from 30 fraction bits, clamp to +-1
	function automatic fx_t to_fx(input cw_t v);
		logic signed [CW:0] r;
		logic signed [CW:0] one;
		r   = ($signed({v[CW-1], v}) + ($signed((CW+1)'(1)) <<< (29 - FRACTION_BITS)))
			>>> (30 - FRACTION_BITS);
		one = $signed((CW+1)'(1)) <<< FRACTION_BITS;
		if (r > one)
			r = one;
		else if (r < -one)
			r = -one;
		return FW'(r);
	endfunction

	function automatic fx_t mul(input fx_t a, input fx_t b);
		logic signed [2*FW-1:0] p;
		p = ($signed({{FW{a[FW-1]}}, a}) * $signed({{FW{b[FW-1]}}, b}))
			+ $signed((2*FW)'(1) <<< (FRACTION_BITS - 1));
		p = p >>> FRACTION_BITS;
		return FW'(p);
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [FW+1:0] v);
		logic signed [FW+16:0] r;
		if (FRACTION_BITS >= 15)
			r = ($signed({{15{v[FW+1]}}, v}) + $signed((FW+17)'(FRACTION_BITS > 15 ?
				(1 <<< (FRACTION_BITS - 16)) : 0))) >>> (FRACTION_BITS >= 15 ?
				FRACTION_BITS - 15 : 0);
		else
			r = $signed({{15{v[FW+1]}}, v}) <<< (FRACTION_BITS < 15 ? 15 - FRACTION_BITS : 0);
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

endpackage

/* design/euler_zyz_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_zyz_rotation_matrix
// Pipelined ZYZ Euler / 2D rotation matrix generator, Q1.15 output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a mode and three angles, each an
// unsigned fraction of a full turn. Output channel (out_valid/out_ready)
// returns the nine entries r11..r33 of the rotation matrix, signed Q1.15.
// The accepting edge loads each angle into its own CORDIC pipeline, which
// then runs 30 stages, one micro-rotation per stage; three more stages do
// rounding, first products and final products, and one stage the Q1.15
// conversion. One beat is taken every cycle unless the output stalls.
// A stall at the output freezes the whole pipeline; every stage holds its
// beat, so nothing is lost or repeated, and in_ready drops only when the
// output register is full and not being taken. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module euler_zyz_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [15:0]        alpha_angle,
	input  logic [15:0]        beta_angle,
	input  logic [15:0]        gamma_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] r11,
	output logic signed [15:0] r12,
	output logic signed [15:0] r13,
	output logic signed [15:0] r21,
	output logic signed [15:0] r22,
	output logic signed [15:0] r23,
	output logic signed [15:0] r31,
	output logic signed [15:0] r32,
	output logic signed [15:0] r33
);
	import ezr_pkg::*;

	localparam int NS = STEPS + 4;

	logic adv;
	logic [NS:0] v_s;
	assign adv      = !v_s[NS] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s[NS];

	// cordic state per stage, three angles
	cw_t x_s [3][STEPS+1];
	cw_t y_s [3][STEPS+1];
	cw_t z_s [3][STEPS+1];
	logic [1:0] q_s [3][STEPS+1];
	logic cmd_s [STEPS+3];

	logic [15:0] ang [3];
	assign ang[0] = alpha_angle;
	assign ang[1] = beta_angle;
	assign ang[2] = gamma_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[NS-1:0], in_valid};
	end

	genvar a, i;
	generate
		for (a = 0; a < 3; a++) begin : g_ang
			logic [31:0] ph;
			assign ph = {ang[a][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
			always_ff @(posedge clk) begin
				if (adv) begin
					x_s[a][0] <= X0;
					y_s[a][0] <= '0;
					z_s[a][0] <= cw_t'({1'b0, 2'b00, ph[29:0]});
					q_s[a][0] <= ph[31:30];
				end
			end
			for (i = 0; i < STEPS; i++) begin : g_st
				cw_t dx, dy;
				assign dx = y_s[a][i] >>> i;
				assign dy = x_s[a][i] >>> i;
				always_ff @(posedge clk) begin
					if (adv) begin
						q_s[a][i+1] <= q_s[a][i];
						if (!z_s[a][i][CW-1]) begin
							x_s[a][i+1] <= x_s[a][i] - dx;
							y_s[a][i+1] <= y_s[a][i] + dy;
							z_s[a][i+1] <= z_s[a][i] - atan_of(i);
						end else begin
							x_s[a][i+1] <= x_s[a][i] + dx;
							y_s[a][i+1] <= y_s[a][i] - dy;
							z_s[a][i+1] <= z_s[a][i] + atan_of(i);
						end
					end
				end
			end
		end
		for (i = 0; i < STEPS + 2; i++) begin : g_cmd
			always_ff @(posedge clk) begin
				if (adv)
					cmd_s[i+1] <= cmd_s[i];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv)
			cmd_s[0] <= command;
	end

	// rounding and quadrant
	fx_t c_r [3];
	fx_t s_r [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				case (q_s[k][STEPS])
					2'd0: begin
						c_r[k] <= to_fx(x_s[k][STEPS]);
						s_r[k] <= to_fx(y_s[k][STEPS]);
					end
					2'd1: begin
						c_r[k] <= to_fx(-y_s[k][STEPS]);
						s_r[k] <= to_fx(x_s[k][STEPS]);
					end
					2'd2: begin
						c_r[k] <= to_fx(-x_s[k][STEPS]);
						s_r[k] <= to_fx(-y_s[k][STEPS]);
					end
					default: begin
						c_r[k] <= to_fx(y_s[k][STEPS]);
						s_r[k] <= to_fx(-x_s[k][STEPS]);
					end
				endcase
			end
		end
	end

	// first products
	fx_t t_p, u_p, cA_p, sA_p, cB_p, sB_p, cG_p, sG_p;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_p  <= mul(c_r[0], c_r[1]);
			u_p  <= mul(c_r[1], s_r[0]);
			cA_p <= c_r[0];
			sA_p <= s_r[0];
			cB_p <= c_r[1];
			sB_p <= s_r[1];
			cG_p <= c_r[2];
			sG_p <= s_r[2];
		end
	end

	// second products and sums
	typedef logic signed [FW+1:0] mw_t;
	mw_t m_f [9];
	logic one_cmd;
	assign one_cmd = cmd_s[STEPS+2];
	always_ff @(posedge clk) begin
		if (adv) begin
			if (one_cmd) begin
				m_f[0] <= mw_t'(cA_p);
				m_f[1] <= -mw_t'(sA_p);
				m_f[2] <= '0;
				m_f[3] <= mw_t'(sA_p);
				m_f[4] <= mw_t'(cA_p);
				m_f[5] <= '0;
				m_f[6] <= '0;
				m_f[7] <= '0;
				m_f[8] <= mw_t'(1) <<< FRACTION_BITS;
			end else begin
				m_f[0] <= mw_t'(mul(t_p, cG_p)) - mw_t'(mul(sA_p, sG_p));
				m_f[1] <= -mw_t'(mul(cG_p, sA_p)) - mw_t'(mul(t_p, sG_p));
				m_f[2] <= mw_t'(mul(cA_p, sB_p));
				m_f[3] <= mw_t'(mul(cA_p, sG_p)) + mw_t'(mul(u_p, cG_p));
				m_f[4] <= mw_t'(mul(cA_p, cG_p)) - mw_t'(mul(u_p, sG_p));
				m_f[5] <= mw_t'(mul(sA_p, sB_p));
				m_f[6] <= -mw_t'(mul(cG_p, sB_p));
				m_f[7] <= mw_t'(mul(sB_p, sG_p));
				m_f[8] <= mw_t'(cB_p);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r11 <= to_q15(m_f[0]);
			r12 <= to_q15(m_f[1]);
			r13 <= to_q15(m_f[2]);
			r21 <= to_q15(m_f[3]);
			r22 <= to_q15(m_f[4]);
			r23 <= to_q15(m_f[5]);
			r31 <= to_q15(m_f[6]);
			r32 <= to_q15(m_f[7]);
			r33 <= to_q15(m_f[8]);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r11) && $stable(r33))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s[0])
		else $error("accepted beat lost");

endmodule
